// File: rtl/tfp_pkg.sv
// tilt fusion pid package: payload structs, register indexes, cordic table
// and rounding / saturation helpers
// no dependencies
`timescale 1ns / 1ps

package tfp_pkg;

  localparam int ANGLE_W      = 24;
  localparam int ERR_W        = ANGLE_W + 1;
  localparam int CORDIC_STEPS = 18;
  localparam int REG_IDX_W    = 3;

  localparam logic [24:0] GYRO_SCALE = 25'd15380219;

  // ceil(2^51 / 1000) split at bit 21
  localparam logic [20:0] DIV1000_HI = 21'd1073741;
  localparam logic [20:0] DIV1000_LO = 21'd1728054;

  localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_P = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KEEP   = 3'd5;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_rate_x;
    logic        [15:0] elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] fused_angle;
    logic signed [31:0]        drive;
    logic                      integ_at_limit;
  } result_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [22:0] atan_entry(input logic [4:0] idx);
    logic [22:0] v;
    unique case (idx)
      5'd0:    v = 23'd2949120;
      5'd1:    v = 23'd1740967;
      5'd2:    v = 23'd919879;
      5'd3:    v = 23'd466945;
      5'd4:    v = 23'd234379;
      5'd5:    v = 23'd117304;
      5'd6:    v = 23'd58666;
      5'd7:    v = 23'd29335;
      5'd8:    v = 23'd14668;
      5'd9:    v = 23'd7334;
      5'd10:   v = 23'd3667;
      5'd11:   v = 23'd1833;
      5'd12:   v = 23'd917;
      5'd13:   v = 23'd458;
      5'd14:   v = 23'd229;
      5'd15:   v = 23'd115;
      5'd16:   v = 23'd57;
      5'd17:   v = 23'd29;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  // divide by 2^n, rounding half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input logic [5:0] n);
    logic [63:0] mag;
    logic [63:0] half;
    logic [63:0] q;
    mag  = v[63] ? 64'(-v) : 64'(v);
    half = (64'd1 << n) >> 1;
    q    = (mag + half) >> n;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  // saturate to w signed bits
  function automatic logic signed [63:0] sat_s(input logic signed [63:0] v,
                                               input int w);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (w - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

endpackage

// File: rtl/tilt_fusion_pid_core.sv
// tilt fusion pid core: tilt estimate (root, cordic, complementary filter)
// followed by a pid with clamped integral, on one shared multiplier
// depends on tfp_pkg
// the first sample after reset only loads the filter with its roll angle and gives
// zero drive; the 64-step divider runs once for each later sample
// ready is low while a sample is in work; the result register frees the input
// reset: synchronous, clears the filter and pid state and loads register defaults
`timescale 1ns / 1ps

module tilt_fusion_pid_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  tfp_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output tfp_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = tfp_pkg::ANGLE_W;
  localparam int EW = tfp_pkg::ERR_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQ0   = 5'd1;
  localparam logic [4:0] S_SQ1   = 5'd2;
  localparam logic [4:0] S_SQ2   = 5'd3;
  localparam logic [4:0] S_SQRT  = 5'd4;
  localparam logic [4:0] S_CINIT = 5'd5;
  localparam logic [4:0] S_CORD  = 5'd6;
  localparam logic [4:0] S_ROLL  = 5'd7;
  localparam logic [4:0] S_SEL   = 5'd8;
  localparam logic [4:0] S_G1    = 5'd9;
  localparam logic [4:0] S_G2    = 5'd10;
  localparam logic [4:0] S_F0    = 5'd11;
  localparam logic [4:0] S_F1    = 5'd12;
  localparam logic [4:0] S_F2    = 5'd13;
  localparam logic [4:0] S_F3    = 5'd14;
  localparam logic [4:0] S_F4    = 5'd15;
  localparam logic [4:0] S_E0    = 5'd16;
  localparam logic [4:0] S_E1    = 5'd17;
  localparam logic [4:0] S_E2    = 5'd18;
  localparam logic [4:0] S_P0    = 5'd19;
  localparam logic [4:0] S_P1    = 5'd20;
  localparam logic [4:0] S_P2    = 5'd21;
  localparam logic [4:0] S_P3    = 5'd22;
  localparam logic [4:0] S_P4    = 5'd23;
  localparam logic [4:0] S_DDIV  = 5'd24;
  localparam logic [4:0] S_DONE  = 5'd25;
  localparam logic [4:0] S_E3    = 5'd26;
  localparam logic [4:0] S_E4    = 5'd27;

  // config registers
  logic signed [16:0] target_angle;
  logic [15:0]        gain_prop;
  logic [15:0]        gain_integ;
  logic [15:0]        gain_deriv;
  logic [22:0]        integ_limit;
  logic [15:0]        gyro_keep;

  // filter and pid state
  logic signed [AW-1:0] angle_est;
  logic signed [23:0]   error_sum;
  logic signed [EW-1:0] prior_error;
  logic                 primed;

  logic [4:0]           state;
  logic [5:0]           cnt;
  tfp_pkg::sample_t     smp;
  logic [15:0]          dt;

  // shared multiplier
  logic signed [47:0]   mul_a;
  logic signed [25:0]   mul_b;
  logic signed [73:0]   mul_full;
  logic signed [63:0]   prod;

  logic signed [63:0]   acc;
  logic signed [47:0]   tmp;
  logic signed [EW-1:0] err;
  logic signed [EW:0]   err_delta;
  logic signed [63:0]   drive_acc;
  logic                 clamped;

  // square root
  logic [31:0]          sq_rem;
  logic [31:0]          sq_root;
  logic [31:0]          sq_bit;
  logic [31:0]          sq_trial;

  // cordic
  logic signed [35:0]   cx;
  logic signed [35:0]   cy;
  logic signed [24:0]   cz;
  logic signed [35:0]   cxs;
  logic signed [35:0]   cys;
  logic signed [24:0]   catan;
  logic signed [16:0]   neg_ax;
  logic                 zero_vec;
  logic signed [17:0]   roll;

  // divider
  logic [63:0]          dv_num;
  logic [31:0]          dv_rem;
  logic [31:0]          dv_d;
  logic                 dv_neg;
  logic [32:0]          dv_rem_sh;
  logic                 dv_qbit;
  logic [31:0]          dv_rem_next;
  logic [63:0]          dv_quo;
  logic signed [63:0]   dv_q;
  logic [63:0]          prod_mag;
  logic [63:0]          e_qmag;
  logic signed [63:0]   e_q;
  logic signed [63:0]   esum_new;
  logic signed [63:0]   lim;

  assign sample_ready = (state == S_IDLE);
  assign pready       = 1'b1;

  assign mul_full  = mul_a * mul_b;
  assign err_delta = (EW + 1)'(err) - (EW + 1)'(prior_error);

  assign sq_trial = sq_root + sq_bit;
  assign cxs      = cx >>> cnt[4:0];
  assign cys      = cy >>> cnt[4:0];
  assign catan    = $signed({2'b00, tfp_pkg::atan_entry(cnt[4:0])});
  assign neg_ax   = -17'(smp.accel_x);

  assign dv_rem_sh   = {dv_rem, dv_num[63]};
  assign dv_qbit     = (dv_rem_sh >= {1'b0, dv_d});
  assign dv_rem_next = dv_qbit ? 32'(dv_rem_sh - {1'b0, dv_d}) : dv_rem_sh[31:0];
  assign dv_quo      = {dv_num[62:0], dv_qbit};
  assign dv_q        = dv_neg ? -$signed(dv_quo) : $signed(dv_quo);
  assign prod_mag    = prod[63] ? 64'(-prod) : 64'(prod);
  // divide by 1000 through the split reciprocal
  assign e_qmag      = ($unsigned(prod) + $unsigned(acc)) >> 30;
  assign e_q         = dv_neg ? -$signed(e_qmag) : $signed(e_qmag);
  assign esum_new    = 64'(error_sum) + e_q;
  assign lim         = $signed({41'd0, integ_limit});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ0: begin
        mul_a = 48'(smp.accel_y);
        mul_b = 26'(smp.accel_y);
      end
      S_SQ1: begin
        mul_a = 48'(smp.accel_z);
        mul_b = 26'(smp.accel_z);
      end
      S_SEL: begin
        mul_a = 48'(smp.gyro_rate_x);
        mul_b = $signed({10'd0, dt});
      end
      S_G1: begin
        mul_a = $signed(prod[47:0]);
        mul_b = $signed({1'b0, tfp_pkg::GYRO_SCALE});
      end
      S_F0: begin
        mul_a = tmp;
        mul_b = $signed({10'd0, gyro_keep});
      end
      S_F1: begin
        mul_a = 48'(roll);
        mul_b = $signed({9'd0, 17'h10000 - {1'b0, gyro_keep}});
      end
      S_E0: begin
        mul_a = 48'(err);
        mul_b = $signed({10'd0, dt});
      end
      S_E2: begin
        mul_a = $signed(dv_num[47:0]);
        mul_b = $signed({5'd0, tfp_pkg::DIV1000_LO});
      end
      S_E3: begin
        mul_a = $signed(dv_num[47:0]);
        mul_b = $signed({5'd0, tfp_pkg::DIV1000_HI});
      end
      S_P0: begin
        mul_a = 48'(err);
        mul_b = $signed({10'd0, gain_prop});
      end
      S_P1: begin
        mul_a = 48'(error_sum);
        mul_b = $signed({10'd0, gain_integ});
      end
      S_P2: begin
        mul_a = 48'(err_delta);
        mul_b = 26'sd1000;
      end
      S_P3: begin
        mul_a = $signed(prod[47:0]);
        mul_b = $signed({10'd0, gain_deriv});
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (paddr[4:2])
      tfp_pkg::REG_TARGET: prdata = 32'(target_angle);
      tfp_pkg::REG_GAIN_P: prdata = {16'd0, gain_prop};
      tfp_pkg::REG_GAIN_I: prdata = {16'd0, gain_integ};
      tfp_pkg::REG_GAIN_D: prdata = {16'd0, gain_deriv};
      tfp_pkg::REG_LIMIT:  prdata = {9'd0, integ_limit};
      tfp_pkg::REG_KEEP:   prdata = {16'd0, gyro_keep};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle <= 17'sd0;
      gain_prop    <= 16'd4096;
      gain_integ   <= 16'd205;
      gain_deriv   <= 16'd1024;
      integ_limit  <= 23'd25600;
      gyro_keep    <= 16'd64225;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        tfp_pkg::REG_TARGET: target_angle <= $signed(pwdata[16:0]);
        tfp_pkg::REG_GAIN_P: gain_prop    <= pwdata[15:0];
        tfp_pkg::REG_GAIN_I: gain_integ   <= pwdata[15:0];
        tfp_pkg::REG_GAIN_D: gain_deriv   <= pwdata[15:0];
        tfp_pkg::REG_LIMIT:  integ_limit  <= pwdata[22:0];
        tfp_pkg::REG_KEEP:   gyro_keep    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      angle_est    <= '0;
      error_sum    <= '0;
      prior_error  <= '0;
      primed       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            smp   <= sample;
            dt    <= (sample.elapsed_ms == 16'd0) ? 16'd1 : sample.elapsed_ms;
            state <= S_SQ0;
          end
        end
        S_SQ0: state <= S_SQ1;
        S_SQ1: begin
          acc   <= prod;
          state <= S_SQ2;
        end
        S_SQ2: begin
          sq_rem  <= acc[31:0] + prod[31:0];
          sq_root <= '0;
          sq_bit  <= 32'h4000_0000;
          cnt     <= '0;
          state   <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_rem >= sq_trial) begin
            sq_rem  <= sq_rem - sq_trial;
            sq_root <= (sq_root >> 1) + sq_bit;
          end else begin
            sq_root <= sq_root >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt + 6'd1;
          if (cnt == 6'd15) begin
            state <= S_CINIT;
          end
        end
        S_CINIT: begin
          cx       <= $signed({4'd0, sq_root}) <<< 14;
          cy       <= 36'(neg_ax) <<< 14;
          cz       <= '0;
          zero_vec <= (sq_root == 32'd0) && (smp.accel_x == 16'sd0);
          cnt      <= '0;
          state    <= S_CORD;
        end
        S_CORD: begin
          if (!cy[35]) begin
            cx <= cx + cys;
            cy <= cy - cxs;
            cz <= cz + catan;
          end else begin
            cx <= cx - cys;
            cy <= cy + cxs;
            cz <= cz - catan;
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(tfp_pkg::CORDIC_STEPS - 1)) begin
            state <= S_ROLL;
          end
        end
        S_ROLL: begin
          roll  <= zero_vec ? 18'sd0 : 18'(tfp_pkg::rnd_shr(64'(cz), 6'd8));
          state <= S_SEL;
        end
        S_SEL: begin
          if (!primed) begin
            angle_est <= AW'(roll);
            primed    <= 1'b1;
            drive_acc <= '0;
            clamped   <= 1'b0;
            state     <= S_DONE;
          end else begin
            state <= S_G1;
          end
        end
        S_G1: state <= S_G2;
        S_G2: begin
          tmp   <= 48'(tfp_pkg::rnd_shr(prod, 6'd32)) + 48'(angle_est);
          state <= S_F0;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          acc   <= prod;
          state <= S_F2;
        end
        S_F2: begin
          acc   <= acc + prod;
          state <= S_F3;
        end
        S_F3: begin
          angle_est <= AW'(tfp_pkg::sat_s(tfp_pkg::rnd_shr(acc, 6'd16), AW));
          state     <= S_F4;
        end
        S_F4: begin
          err   <= EW'(tfp_pkg::sat_s(64'(target_angle) - 64'(angle_est), EW));
          state <= S_E0;
        end
        S_E0: state <= S_E1;
        S_E1: begin
          dv_neg <= prod[63];
          dv_num <= prod_mag + 64'd500;
          state  <= S_E2;
        end
        S_E2: state <= S_E3;
        S_E3: begin
          acc   <= prod >>> 21;
          state <= S_E4;
        end
        S_E4: begin
          if (esum_new > lim) begin
            error_sum <= 24'(lim);
            clamped   <= 1'b1;
          end else if (esum_new < -lim) begin
            error_sum <= 24'(-lim);
            clamped   <= 1'b1;
          end else begin
            error_sum <= 24'(esum_new);
            clamped   <= 1'b0;
          end
          state <= S_P0;
        end
        S_P4: begin
          dv_neg <= prod[63];
          dv_num <= prod_mag + 64'({dt, 11'd0});
          dv_rem <= '0;
          dv_d   <= {4'd0, dt, 12'd0};
          cnt    <= '0;
          state  <= S_DDIV;
        end
        S_DDIV: begin
          dv_num <= dv_quo;
          dv_rem <= dv_rem_next;
          cnt    <= cnt + 6'd1;
          if (&cnt) begin
            drive_acc   <= drive_acc + dv_q;
            prior_error <= err;
            state       <= S_DONE;
          end
        end
        S_P0: state <= S_P1;
        S_P1: begin
          drive_acc <= tfp_pkg::rnd_shr(prod, 6'd12);
          state     <= S_P2;
        end
        S_P2: begin
          drive_acc <= drive_acc + tfp_pkg::rnd_shr(prod, 6'd12);
          state     <= S_P3;
        end
        S_P3: state <= S_P4;
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result.fused_angle    <= angle_est;
            result.drive          <= 32'(tfp_pkg::sat_s(drive_acc, 32));
            result.integ_at_limit <= clamped;
            result_valid          <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
